// ===== hdl/tts_pkg.sv =====
// Shared types and constants for the tick task scheduler.
// No dependencies; compile before the interfaces and the core.
package tts_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int TAG_W          = 8;
  localparam int TIME_W         = 16;
  localparam int IDX_IN_W       = 4;
  localparam int COUNT_OUT_W    = 5;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2,
    OP_DISP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_SLOT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_WB,
    S_SH_CHK,
    S_SH_WR,
    S_EM_RD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] countdown;
    logic [TIME_W-1:0] period;
  } entry_t;

endpackage

// ===== hdl/tts_in_if.sv =====
// Request channel of the tick task scheduler: valid/ready plus one operation.
// Depends on tts_pkg for field widths.
interface tts_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [tts_pkg::TAG_W-1:0]     task_tag;
  logic [tts_pkg::TIME_W-1:0]    first_delay;
  logic [tts_pkg::TIME_W-1:0]    repeat_period;
  logic [tts_pkg::IDX_IN_W-1:0]  slot_index;

  modport source (output valid, op, task_tag, first_delay, repeat_period, slot_index,
                  input ready);
  modport sink   (input valid, op, task_tag, first_delay, repeat_period, slot_index,
                  output ready);
endinterface

// ===== hdl/tts_out_if.sv =====
// Result channel of the tick task scheduler: valid/ready plus one result.
// Depends on tts_pkg for field widths.
interface tts_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic                             fired;
  logic [tts_pkg::TAG_W-1:0]        fired_tag;
  logic [tts_pkg::COUNT_OUT_W-1:0]  task_count;
  logic                             last;

  modport source (output valid, status, fired, fired_tag, task_count, last, input ready);
  modport sink   (input valid, status, fired, fired_tag, task_count, last, output ready);
endinterface

// ===== hdl/tick_task_scheduler_core.sv =====
// Tick task scheduler core: task table, sequencer and result buffer.
// Depends on tts_pkg, tts_in_if and tts_out_if.
//
// One request is handled at a time; in_if.ready is high only while idle.
// All table work goes through a single task memory with one registered read
// port and one write port, so each slot visit that reads has a read state
// and a write-back state. Delete and dispatch remove a task by shifting the
// later entries down. Dispatch reads every ready task and removes one-shot
// tasks, then delivers one result per ready task, or one empty result (the
// tags are buffered so that every result can carry the final task count).
// No clearing pass is needed after reset.
module tick_task_scheduler_core #(
  parameter int TASK_SLOTS = tts_pkg::TASK_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tts_in_if.sink     in_if,
  tts_out_if.source  out_if
);

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int RW = $clog2(tts_pkg::MAX_RESULTS);
  localparam int NW = $clog2(tts_pkg::MAX_RESULTS + 1);
  localparam int TW = tts_pkg::TAG_W;
  localparam int DW = tts_pkg::TIME_W;

  tts_pkg::state_t  state_r, state_nxt;
  tts_pkg::op_t     op_r, op_nxt;
  tts_pkg::status_t status_r, status_nxt;
  logic [TW-1:0]    tag_r, tag_nxt;
  logic [DW-1:0]    delay_r, delay_nxt;
  logic [DW-1:0]    period_r, period_nxt;
  logic [tts_pkg::IDX_IN_W-1:0] slot_r, slot_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [IW-1:0]    sh_r, sh_nxt;
  logic [NW-1:0]    nres_r, nres_nxt;
  logic [RW-1:0]    emit_r, emit_nxt;
  logic             fired_r, fired_nxt;
  logic             last_r, last_nxt;
  logic [TASK_SLOTS-1:0] rdy_r, rdy_nxt;

  // task table and dispatch tag buffer
  tts_pkg::entry_t  mem_r [TASK_SLOTS];
  tts_pkg::entry_t  rd_q;
  logic [TW-1:0]    buf_r [tts_pkg::MAX_RESULTS];
  logic [TW-1:0]    buf_q;

  logic             mem_re, mem_we, buf_re, buf_we;
  logic [IW-1:0]    mem_ra, mem_wa;
  tts_pkg::entry_t  mem_wd;
  logic [RW-1:0]    buf_wa;
  logic [TW-1:0]    buf_wd;

  logic [IW-1:0]    idx_w;
  logic [CW-1:0]    sh_p1;
  logic             scan_done;

  assign idx_w     = idx_r[IW-1:0];
  assign sh_p1     = CW'(sh_r) + CW'(1);
  assign scan_done = (idx_r >= cnt_r) ||
                     ((op_r == tts_pkg::OP_DISP) && (nres_r == NW'(tts_pkg::MAX_RESULTS)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tts_pkg::S_IDLE;
      cnt_r   <= '0;
      rdy_r   <= '0;
      idx_r   <= '0;
      nres_r  <= '0;
      emit_r  <= '0;
      sh_r    <= '0;
      fired_r <= 1'b0;
      last_r  <= 1'b0;
      op_r    <= tts_pkg::OP_ADD;
      status_r <= tts_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rdy_r   <= rdy_nxt;
      idx_r   <= idx_nxt;
      nres_r  <= nres_nxt;
      emit_r  <= emit_nxt;
      sh_r    <= sh_nxt;
      fired_r <= fired_nxt;
      last_r  <= last_nxt;
      op_r    <= op_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r    <= tag_nxt;
    delay_r  <= delay_nxt;
    period_r <= period_nxt;
    slot_r   <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_r[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[buf_wa] <= buf_wd;
    end
    if (buf_re) begin
      buf_q <= buf_r[emit_r];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    tag_nxt    = tag_r;
    delay_nxt  = delay_r;
    period_nxt = period_r;
    slot_nxt   = slot_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    sh_nxt     = sh_r;
    nres_nxt   = nres_r;
    emit_nxt   = emit_r;
    fired_nxt  = fired_r;
    last_nxt   = last_r;
    rdy_nxt    = rdy_r;
    mem_re     = 1'b0;
    mem_ra     = idx_w;
    mem_we     = 1'b0;
    mem_wa     = idx_w;
    mem_wd     = rd_q;
    buf_re     = 1'b0;
    buf_we     = 1'b0;
    buf_wa     = nres_r[RW-1:0];
    buf_wd     = rd_q.tag;
    in_if.ready = 1'b0;

    unique case (state_r)
      tts_pkg::S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          op_nxt     = tts_pkg::op_t'(in_if.op);
          tag_nxt    = in_if.task_tag;
          delay_nxt  = in_if.first_delay;
          period_nxt = in_if.repeat_period;
          slot_nxt   = in_if.slot_index;
          state_nxt  = tts_pkg::S_EXEC;
        end
      end

      tts_pkg::S_EXEC: begin
        status_nxt = tts_pkg::ST_OK;
        fired_nxt  = 1'b0;
        last_nxt   = 1'b1;
        idx_nxt    = '0;
        nres_nxt   = '0;
        unique case (op_r) inside
          tts_pkg::OP_ADD: begin
            state_nxt = tts_pkg::S_OUT;
            if (cnt_r >= CW'(TASK_SLOTS)) begin
              status_nxt = tts_pkg::ST_FULL;
            end else begin
              mem_we  = 1'b1;
              mem_wa  = cnt_r[IW-1:0];
              mem_wd  = '{tag: tag_r, countdown: delay_r, period: period_r};
              rdy_nxt[cnt_r[IW-1:0]] = 1'b0;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          tts_pkg::OP_DEL: begin
            if (8'(slot_r) >= 8'(cnt_r)) begin
              status_nxt = tts_pkg::ST_BAD_SLOT;
              state_nxt  = tts_pkg::S_OUT;
            end else begin
              sh_nxt    = IW'(slot_r);
              state_nxt = tts_pkg::S_SH_CHK;
            end
          end
          tts_pkg::OP_TICK, tts_pkg::OP_DISP: begin
            state_nxt = tts_pkg::S_SCAN;
          end
          default: state_nxt = tts_pkg::S_IDLE;
        endcase
      end

      tts_pkg::S_SCAN: begin
        if (scan_done) begin
          fired_nxt = 1'b0;
          last_nxt  = 1'b1;
          if ((op_r == tts_pkg::OP_DISP) && (nres_r != '0)) begin
            emit_nxt  = '0;
            state_nxt = tts_pkg::S_EM_RD;
          end else begin
            state_nxt = tts_pkg::S_OUT;
          end
        end else if ((op_r == tts_pkg::OP_TICK) || rdy_r[idx_w]) begin
          mem_re    = 1'b1;
          state_nxt = tts_pkg::S_WB;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      tts_pkg::S_WB: begin
        if (op_r == tts_pkg::OP_TICK) begin
          // zero countdown: ready now, countdown stays at zero
          if (rd_q.countdown != '0) begin
            mem_we = 1'b1;
            mem_wd = '{tag: rd_q.tag, countdown: rd_q.countdown - DW'(1),
                       period: rd_q.period};
          end else begin
            rdy_nxt[idx_w] = 1'b1;
          end
          idx_nxt   = idx_r + CW'(1);
          state_nxt = tts_pkg::S_SCAN;
        end else begin
          buf_we   = 1'b1;
          nres_nxt = nres_r + NW'(1);
          rdy_nxt[idx_w] = 1'b0;
          if (rd_q.period != '0) begin
            mem_we    = 1'b1;
            mem_wd    = '{tag: rd_q.tag, countdown: rd_q.period, period: rd_q.period};
            idx_nxt   = idx_r + CW'(1);
            state_nxt = tts_pkg::S_SCAN;
          end else begin
            // one-shot: remove it and rescan the same slot afterwards
            sh_nxt    = idx_w;
            state_nxt = tts_pkg::S_SH_CHK;
          end
        end
      end

      tts_pkg::S_SH_CHK: begin
        if (sh_p1 < cnt_r) begin
          mem_re    = 1'b1;
          mem_ra    = sh_p1[IW-1:0];
          state_nxt = tts_pkg::S_SH_WR;
        end else begin
          rdy_nxt[sh_r] = 1'b0;
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = (op_r == tts_pkg::OP_DISP) ? tts_pkg::S_SCAN : tts_pkg::S_OUT;
        end
      end

      tts_pkg::S_SH_WR: begin
        mem_we        = 1'b1;
        mem_wa        = sh_r;
        mem_wd        = rd_q;
        rdy_nxt[sh_r] = rdy_r[sh_p1[IW-1:0]];
        sh_nxt        = sh_p1[IW-1:0];
        state_nxt     = tts_pkg::S_SH_CHK;
      end

      tts_pkg::S_EM_RD: begin
        buf_re    = 1'b1;
        fired_nxt = 1'b1;
        last_nxt  = ((NW'(emit_r) + NW'(1)) == nres_r);
        state_nxt = tts_pkg::S_OUT;
      end

      tts_pkg::S_OUT: begin
        if (out_if.ready) begin
          if (last_r) begin
            state_nxt = tts_pkg::S_IDLE;
          end else begin
            emit_nxt  = emit_r + RW'(1);
            state_nxt = tts_pkg::S_EM_RD;
          end
        end
      end

      default: state_nxt = tts_pkg::S_IDLE;
    endcase
  end

  assign out_if.valid      = (state_r == tts_pkg::S_OUT);
  assign out_if.status     = status_r;
  assign out_if.fired      = fired_r;
  assign out_if.fired_tag  = fired_r ? buf_q : '0;
  assign out_if.task_count = tts_pkg::COUNT_OUT_W'(cnt_r);
  assign out_if.last       = last_r;

endmodule

// ===== hdl/tts_checker.sv =====
// Port-level checks for the tick task scheduler core, bound into the core.
// Depends on tts_pkg and tick_task_scheduler_core.
module tts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic       out_fired,
  input logic       out_last
);

  // a request is never taken while a result is still on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while result pending");

  // a dispatched tag always comes with an ok status
  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fired) |-> (out_status == tts_pkg::ST_OK))
    else $error("fired result with error status");

  // error results stand alone
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != tts_pkg::ST_OK)) |-> (out_last && !out_fired))
    else $error("error result not single");

  // after the final result the block is ready again at once
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("not ready after final result");

  // a request is followed by a busy cycle, never an immediate second take
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready straight after request");

endmodule

bind tick_task_scheduler_core tts_checker u_tts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_status (out_if.status),
  .out_fired  (out_if.fired),
  .out_last   (out_if.last)
);
